// ===== rtl/spadd_pkg.sv =====
`default_nettype none

package spadd_pkg;

  localparam int COEFF_W = 16;
  localparam int EXP_W   = 8;
  localparam int SUM_W   = 17;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE       = 2'd2;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic step;
  } spadd_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic step_last;
  } spadd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sparse_polynomial_add_merge.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_cmd, in_coeff, in_exponent
// out       out_valid / out_ready  out_sum_coeff, out_exponent, out_last_term,
//                                  out_empty_result, out_overflow_seen
//
// Load items are accepted back to back.
// A merge item emits one term per cycle (count of terms, or one if both
// lists are empty); input is held off until the final term is registered.
// Output stalls freeze the merge step; the single output register sets the rate.
// Synchronous active-low reset clears counts, pointers, overflow and valid.
`default_nettype none

module sparse_polynomial_add_merge #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [spadd_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic signed [spadd_pkg::COEFF_W-1:0] in_coeff,
  input  wire logic [spadd_pkg::EXP_W-1:0]          in_exponent,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [spadd_pkg::SUM_W-1:0]        out_sum_coeff,
  output logic [spadd_pkg::EXP_W-1:0]               out_exponent,
  output logic                                      out_last_term,
  output logic                                      out_empty_result,
  output logic                                      out_overflow_seen
);

  spadd_pkg::spadd_cmd_t  cmd;
  spadd_pkg::spadd_stat_t stat;

  spadd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  spadd_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_coeff          (in_coeff),
    .in_exponent       (in_exponent),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sum_coeff     (out_sum_coeff),
    .out_exponent      (out_exponent),
    .out_last_term     (out_last_term),
    .out_empty_result  (out_empty_result),
    .out_overflow_seen (out_overflow_seen)
  );

endmodule

`default_nettype wire

// ===== rtl/spadd_ctrl.sv =====
`default_nettype none

module spadd_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [spadd_pkg::CMD_W-1:0]   in_cmd,
  input  wire spadd_pkg::spadd_stat_t        stat,
  output spadd_pkg::spadd_cmd_t              cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load_first  = accept && (in_cmd == spadd_pkg::CMD_LOAD_FIRST);
    cmd.load_second = accept && (in_cmd == spadd_pkg::CMD_LOAD_SECOND);
    cmd.step        = (state_r == ST_MERGE) && stat.slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == spadd_pkg::CMD_MERGE)) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (stat.slot_free && stat.step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spadd_dp.sv =====
`default_nettype none

module spadd_dp #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire spadd_pkg::spadd_cmd_t                cmd,
  output spadd_pkg::spadd_stat_t                    stat,
  input  wire logic signed [spadd_pkg::COEFF_W-1:0] in_coeff,
  input  wire logic [spadd_pkg::EXP_W-1:0]          in_exponent,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [spadd_pkg::SUM_W-1:0]        out_sum_coeff,
  output logic [spadd_pkg::EXP_W-1:0]               out_exponent,
  output logic                                      out_last_term,
  output logic                                      out_empty_result,
  output logic                                      out_overflow_seen
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

  localparam int TERM_W = spadd_pkg::COEFF_W + spadd_pkg::EXP_W;

  logic [TERM_W-1:0] first_mem [MAX_TERMS];
  logic [TERM_W-1:0] second_mem [MAX_TERMS];

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] ptr_a_r, ptr_a_nxt;
  logic [CNT_W-1:0] ptr_b_r, ptr_b_nxt;
  logic             ovf_r, ovf_nxt;

  logic                                out_valid_r;
  logic signed [spadd_pkg::SUM_W-1:0]  sum_r;
  logic [spadd_pkg::EXP_W-1:0]         exp_r;
  logic                                last_r;
  logic                                empty_r;
  logic                                ovf_out_r;

  logic [TERM_W-1:0]                   term_a_r, term_b_r;
  logic signed [spadd_pkg::COEFF_W-1:0] coef_a, coef_b;
  logic [spadd_pkg::EXP_W-1:0]         ex_a, ex_b;
  logic                                has_a, has_b;
  logic                                adv_a, adv_b;
  logic                                both_empty;
  logic signed [spadd_pkg::SUM_W-1:0]  add_a, add_b, sum_val;
  logic [CNT_W-1:0]                    ptr_a_step, ptr_b_step;
  logic                                last_val;
  logic                                slot_free;

  assign coef_a = term_a_r[TERM_W-1:spadd_pkg::EXP_W];
  assign coef_b = term_b_r[TERM_W-1:spadd_pkg::EXP_W];
  assign ex_a   = term_a_r[spadd_pkg::EXP_W-1:0];
  assign ex_b   = term_b_r[spadd_pkg::EXP_W-1:0];

  assign has_a      = ptr_a_r < cnt_a_r;
  assign has_b      = ptr_b_r < cnt_b_r;
  assign both_empty = !has_a && !has_b;
  assign adv_a      = has_a && (!has_b || (ex_a >= ex_b));
  assign adv_b      = has_b && (!has_a || (ex_b >= ex_a));

  assign add_a   = adv_a ? {coef_a[spadd_pkg::COEFF_W-1], coef_a} : '0;
  assign add_b   = adv_b ? {coef_b[spadd_pkg::COEFF_W-1], coef_b} : '0;
  assign sum_val = add_a + add_b;

  assign ptr_a_step = ptr_a_r + CNT_W'(adv_a);
  assign ptr_b_step = ptr_b_r + CNT_W'(adv_b);
  assign last_val   = both_empty || ((ptr_a_step == cnt_a_r) && (ptr_b_step == cnt_b_r));

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    stat.slot_free = slot_free;
    stat.step_last = last_val;
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ptr_a_nxt = ptr_a_r;
    ptr_b_nxt = ptr_b_r;
    ovf_nxt   = ovf_r;
    if (cmd.load_first) begin
      if (cnt_a_r < MAX_CNT) begin
        cnt_a_nxt = cnt_a_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.load_second) begin
      if (cnt_b_r < MAX_CNT) begin
        cnt_b_nxt = cnt_b_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.step) begin
      if (last_val) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        ptr_a_nxt = '0;
        ptr_b_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        ptr_a_nxt = ptr_a_step;
        ptr_b_nxt = ptr_b_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ptr_a_r     <= '0;
      ptr_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ptr_a_r     <= ptr_a_nxt;
      ptr_b_r     <= ptr_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= cmd.step || (out_valid_r && !out_ready);
    end
  end

  // read at the next pointer so the term is ready when the pointer lands
  always_ff @(posedge clk) begin
    if (cmd.load_first && (cnt_a_r < MAX_CNT)) begin
      first_mem[cnt_a_r[IDX_W-1:0]] <= {in_coeff, in_exponent};
    end
    if (cmd.load_second && (cnt_b_r < MAX_CNT)) begin
      second_mem[cnt_b_r[IDX_W-1:0]] <= {in_coeff, in_exponent};
    end
    term_a_r <= first_mem[ptr_a_nxt[IDX_W-1:0]];
    term_b_r <= second_mem[ptr_b_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      sum_r     <= both_empty ? '0 : sum_val;
      exp_r     <= both_empty ? '0 : (adv_a ? ex_a : ex_b);
      last_r    <= last_val;
      empty_r   <= both_empty;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sum_coeff     = sum_r;
  assign out_exponent      = exp_r;
  assign out_last_term     = last_r;
  assign out_empty_result  = empty_r;
  assign out_overflow_seen = ovf_out_r;

endmodule

`default_nettype wire

// ===== sim/tb_sparse_polynomial_add_merge.sv =====
module tb_sparse_polynomial_add_merge;

  localparam int MAX_TERMS = 16;
  localparam int SCRIPT_LEN = 23;
  localparam int RANDOM_ITEMS = 380;
  localparam logic [spadd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [spadd_pkg::SUM_W-1:0] coeff;
    logic [spadd_pkg::EXP_W-1:0] expo;
    logic                        last;
    logic                        empty;
    logic                        ovf;
  } merge_term_t;

  typedef struct packed {
    logic [spadd_pkg::CMD_W-1:0]   cmd;
    logic [spadd_pkg::COEFF_W-1:0] coeff;
    logic [spadd_pkg::EXP_W-1:0]   expo;
    logic [4:0]                    reps;
    logic                          fixed;
    merge_term_t                   want;
  } stim_row_t;

  localparam merge_term_t EMPTY_RUN = '{17'd0, 8'd0, 1'b1, 1'b1, 1'b0};
  localparam merge_term_t NO_TERM = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [spadd_pkg::CMD_W-1:0] in_cmd = '0;
  logic signed [spadd_pkg::COEFF_W-1:0] in_coeff = '0;
  logic [spadd_pkg::EXP_W-1:0] in_exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [spadd_pkg::SUM_W-1:0] out_sum_coeff;
  logic [spadd_pkg::EXP_W-1:0] out_exponent;
  logic out_last_term;
  logic out_empty_result;
  logic out_overflow_seen;

  sparse_polynomial_add_merge #(.MAX_TERMS(MAX_TERMS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_coeff(in_coeff),
    .in_exponent(in_exponent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sum_coeff(out_sum_coeff),
    .out_exponent(out_exponent),
    .out_last_term(out_last_term),
    .out_empty_result(out_empty_result),
    .out_overflow_seen(out_overflow_seen)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [spadd_pkg::COEFF_W-1:0] first_coeff [0:MAX_TERMS-1];
  logic [spadd_pkg::EXP_W-1:0]   first_expo  [0:MAX_TERMS-1];
  logic [spadd_pkg::COEFF_W-1:0] second_coeff [0:MAX_TERMS-1];
  logic [spadd_pkg::EXP_W-1:0]   second_expo  [0:MAX_TERMS-1];
  int first_cnt = 0;
  int second_cnt = 0;
  logic dropped_flag = 1'b0;

  merge_term_t merge_q [$];
  merge_term_t term_want;
  stim_row_t script [0:SCRIPT_LEN-1];

  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int runs_done = 0;
  int terms_checked = 0;
  int loads_dropped = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_item(input logic [spadd_pkg::CMD_W-1:0] cmd,
                              input logic [spadd_pkg::COEFF_W-1:0] coeff,
                              input logic [spadd_pkg::EXP_W-1:0] expo, input bit emit);
    merge_term_t run_out [0:2*MAX_TERMS-1];
    int i;
    int j;
    int n;
    i = 0;
    j = 0;
    n = 0;
    case (cmd)
      spadd_pkg::CMD_LOAD_FIRST: begin
        if (first_cnt < MAX_TERMS) begin
          first_coeff[first_cnt] = coeff;
          first_expo[first_cnt] = expo;
          first_cnt++;
        end else begin
          dropped_flag = 1'b1;
          loads_dropped++;
        end
      end
      spadd_pkg::CMD_LOAD_SECOND: begin
        if (second_cnt < MAX_TERMS) begin
          second_coeff[second_cnt] = coeff;
          second_expo[second_cnt] = expo;
          second_cnt++;
        end else begin
          dropped_flag = 1'b1;
          loads_dropped++;
        end
      end
      spadd_pkg::CMD_MERGE: begin
        if (first_cnt == 0 && second_cnt == 0) begin
          run_out[0] = '{17'd0, 8'd0, 1'b0, 1'b1, dropped_flag};
          n = 1;
        end else begin
          while (i < first_cnt && j < second_cnt) begin
            if (first_expo[i] > second_expo[j]) begin
              run_out[n] = '{{first_coeff[i][15], first_coeff[i]}, first_expo[i],
                             1'b0, 1'b0, dropped_flag};
              i++;
            end else if (first_expo[i] < second_expo[j]) begin
              run_out[n] = '{{second_coeff[j][15], second_coeff[j]}, second_expo[j],
                             1'b0, 1'b0, dropped_flag};
              j++;
            end else begin
              run_out[n] = '{{first_coeff[i][15], first_coeff[i]} +
                             {second_coeff[j][15], second_coeff[j]},
                             first_expo[i], 1'b0, 1'b0, dropped_flag};
              i++;
              j++;
            end
            n++;
          end
          while (i < first_cnt) begin
            run_out[n] = '{{first_coeff[i][15], first_coeff[i]}, first_expo[i],
                           1'b0, 1'b0, dropped_flag};
            i++;
            n++;
          end
          while (j < second_cnt) begin
            run_out[n] = '{{second_coeff[j][15], second_coeff[j]}, second_expo[j],
                           1'b0, 1'b0, dropped_flag};
            j++;
            n++;
          end
        end
        run_out[n-1].last = 1'b1;
        if (emit)
          for (i = 0; i < n; i++) merge_q.push_back(run_out[i]);
        first_cnt = 0;
        second_cnt = 0;
        dropped_flag = 1'b0;
        runs_done++;
      end
      default: ;
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [spadd_pkg::CMD_W-1:0] cmd,
                           input logic [spadd_pkg::COEFF_W-1:0] coeff,
                           input logic [spadd_pkg::EXP_W-1:0] expo, input bit fixed,
                           input merge_term_t want);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coeff <= coeff;
    in_exponent <= expo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fixed) merge_q.push_back(want);
    predict_item(cmd, coeff, expo, !fixed);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [spadd_pkg::COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 19))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return MAX_TERMS + $urandom_range(1, 3);
    if (r < 16) return MAX_TERMS;
    return $urandom_range(0, 6);
  endfunction

  always @(negedge clk) out_ready <= calm || $urandom_range(0, 99) >= 6;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (merge_q.size() == 0) begin
        report_mismatch("unexpected term, exponent", out_exponent, 0);
      end else begin
        term_want = merge_q.pop_front();
        terms_checked++;
        if (out_sum_coeff !== term_want.coeff)
          report_mismatch("sum_coeff", out_sum_coeff, $signed(term_want.coeff));
        if (out_exponent !== term_want.expo)
          report_mismatch("exponent", out_exponent, term_want.expo);
        if (out_last_term !== term_want.last)
          report_mismatch("last_term", out_last_term, term_want.last);
        if (out_empty_result !== term_want.empty)
          report_mismatch("empty_result", out_empty_result, term_want.empty);
        if (out_overflow_seen !== term_want.ovf)
          report_mismatch("overflow_seen", out_overflow_seen, term_want.ovf);
      end
    end
  end

  initial begin : stimulus
    logic [spadd_pkg::EXP_W-1:0] list_a [0:MAX_TERMS+3];
    logic [spadd_pkg::EXP_W-1:0] list_b [0:MAX_TERMS+3];
    int r;
    int k;
    int sent;
    int na_want;
    int nb_want;
    int na;
    int nb;
    int ia;
    int ib;
    int cur;
    bit unsorted;
    bit take_a;
    bit take_b;
    bit pick_a;

    script[0]  = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b1, EMPTY_RUN};
    script[1]  = '{CMD_UNUSED,                 16'hffff, 8'd255, 5'd1,  1'b0, NO_TERM};
    script[2]  = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b1, EMPTY_RUN};
    script[3]  = '{spadd_pkg::CMD_LOAD_FIRST,  16'h7fff, 8'd255, 5'd1,  1'b0, NO_TERM};
    script[4]  = '{spadd_pkg::CMD_LOAD_FIRST,  16'h8000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[5]  = '{spadd_pkg::CMD_LOAD_SECOND, 16'h7fff, 8'd255, 5'd1,  1'b0, NO_TERM};
    script[6]  = '{spadd_pkg::CMD_LOAD_SECOND, 16'h8000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[7]  = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[8]  = '{spadd_pkg::CMD_LOAD_FIRST,  16'hfffb, 8'd10,  5'd1,  1'b0, NO_TERM};
    script[9]  = '{spadd_pkg::CMD_LOAD_SECOND, 16'h0005, 8'd10,  5'd1,  1'b0, NO_TERM};
    script[10] = '{spadd_pkg::CMD_LOAD_SECOND, 16'h0007, 8'd3,   5'd1,  1'b0, NO_TERM};
    script[11] = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[12] = '{spadd_pkg::CMD_LOAD_FIRST,  16'h0001, 8'd2,   5'd1,  1'b0, NO_TERM};
    script[13] = '{spadd_pkg::CMD_LOAD_FIRST,  16'h0002, 8'd9,   5'd1,  1'b0, NO_TERM};
    script[14] = '{spadd_pkg::CMD_LOAD_SECOND, 16'h0003, 8'd5,   5'd1,  1'b0, NO_TERM};
    script[15] = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[16] = '{spadd_pkg::CMD_LOAD_FIRST,  16'h1234, 8'd200, 5'd17, 1'b0, NO_TERM};
    script[17] = '{spadd_pkg::CMD_LOAD_SECOND, 16'h8000, 8'd190, 5'd3,  1'b0, NO_TERM};
    script[18] = '{CMD_UNUSED,                 16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[19] = '{spadd_pkg::CMD_MERGE,       16'h5555, 8'd170, 5'd1,  1'b0, NO_TERM};
    script[20] = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b1, EMPTY_RUN};
    script[21] = '{spadd_pkg::CMD_LOAD_SECOND, 16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};
    script[22] = '{spadd_pkg::CMD_MERGE,       16'h0000, 8'd0,   5'd1,  1'b0, NO_TERM};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // repeated rows step coeff up and exponent down
    for (r = 0; r < SCRIPT_LEN; r++)
      for (k = 0; k < script[r].reps; k++)
        send_item(script[r].cmd, script[r].coeff + 16'(k), script[r].expo - 8'(k),
                  script[r].fixed, script[r].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 150 && sent < 260);
      unsorted = ($urandom_range(0, 7) == 0);
      na_want = pick_len();
      nb_want = pick_len();
      na = 0;
      nb = 0;
      cur = 255 - $urandom_range(0, 20);
      while ((na < na_want || nb < nb_want) && cur >= 0) begin
        take_a = na < na_want && ($urandom_range(0, 1) == 1 || nb >= nb_want);
        take_b = nb < nb_want && (!take_a || $urandom_range(0, 2) == 0);
        if (take_a) begin
          list_a[na] = 8'(unsorted ? $urandom_range(0, 255) : cur);
          na++;
        end
        if (take_b) begin
          list_b[nb] = 8'(unsorted ? $urandom_range(0, 255) : cur);
          nb++;
        end
        cur -= $urandom_range(1, 7);
      end
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
        if ($urandom_range(0, 14) == 0)
          send_item(CMD_UNUSED, 16'($urandom), 8'($urandom), 1'b0, NO_TERM);
        pick_a = ib >= nb || (ia < na && $urandom_range(0, 1) == 1);
        if (pick_a) begin
          send_item(spadd_pkg::CMD_LOAD_FIRST, rand_coeff(), list_a[ia], 1'b0, NO_TERM);
          ia++;
        end else begin
          send_item(spadd_pkg::CMD_LOAD_SECOND, rand_coeff(), list_b[ib], 1'b0, NO_TERM);
          ib++;
        end
        sent++;
      end
      // now and then skip the merge so lists pile up across sets
      if ($urandom_range(0, 9) != 0 || sent >= RANDOM_ITEMS) begin
        send_item(spadd_pkg::CMD_MERGE, 16'($urandom), 8'($urandom), 1'b0, NO_TERM);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (merge_q.size() != 0) @(posedge clk);
    repeat (2 * MAX_TERMS + 8) @(posedge clk);

    $display("%0d items sent, %0d merge runs, %0d terms checked", items_sent, runs_done,
             terms_checked);
    $display("%0d loads dropped on full lists, %0d mismatches", loads_dropped, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spadd_pkg.sv
rtl/spadd_ctrl.sv
rtl/spadd_dp.sv
rtl/sparse_polynomial_add_merge.sv
sim/tb_sparse_polynomial_add_merge.sv
